// ===== hw/rtl/wildcard_entry_matcher_top_macros.svh =====
// Assertion helpers for the wildcard entry matcher.
`ifndef WILDCARD_ENTRY_MATCHER_TOP_MACROS_SVH
`define WILDCARD_ENTRY_MATCHER_TOP_MACROS_SVH

// Property holds at every enabled edge.
`define WEM_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define WEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wem_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CH_W        = 8;

    localparam logic [CH_W-1:0] STAR_BYTE  = 8'h2A;
    localparam logic [CH_W-1:0] QUEST_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ENTRY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_GLOB        = 2'd0,
        MODE_GLOB_PREFIX = 2'd1,
        MODE_EXACT       = 2'd2,
        MODE_PREFIX      = 2'd3
    } t_mode;

    typedef logic [PATTERN_MAX-1:0][CH_W-1:0] t_chars;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             overflow;
    } t_pat_status;

    // Every active position sitting on a star also activates the next one,
    // through whole runs of stars. Done as a carry chain: the carry into
    // bit k is set when a source bit on a star is followed by stars up to k.
    function automatic logic [POS_W-1:0] f_star_closure(
        input logic [POS_W-1:0]       src,
        input logic [PATTERN_MAX-1:0] star
    );
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] g;
        logic [POS_W-1:0] carries;
        p       = {1'b0, star};
        g       = src & p;
        carries = (p + g) ^ p ^ g;
        return src | carries;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wem_pattern_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wem_pattern_store (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_append,
    input  wire logic                 i_clear,
    input  wire logic [7:0]           i_ch,
    output wem_pkg::t_chars           o_chars,
    output wem_pkg::t_pat_status      o_status
);
    import wem_pkg::*;

    t_chars           r_chars;
    logic [LEN_W-1:0] r_len;
    logic             r_overflow;
    logic             w_full;

    assign w_full = (r_len == LEN_W'(PATTERN_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_overflow <= 1'b0;
        end else if (i_clear) begin
            r_len      <= '0;
            r_overflow <= 1'b0;
        end else if (i_append) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_len <= r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_append && !w_full) begin
            r_chars[r_len[IDX_W-1:0]] <= i_ch;
        end
    end

    assign o_chars           = r_chars;
    assign o_status.len      = r_len;
    assign o_status.overflow = r_overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/wem_nfa_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wem_nfa_step (
    input  wire logic [wem_pkg::POS_W-1:0] i_active,
    input  var  wem_pkg::t_chars           i_chars,
    input  wire logic [wem_pkg::LEN_W-1:0] i_len,
    input  var  wem_pkg::t_mode            i_mode,
    input  wire logic [7:0]                i_ch,
    output logic [wem_pkg::POS_W-1:0]      o_next,
    output logic                           o_accept
);
    import wem_pkg::*;

    logic                   w_glob;
    logic                   w_tail;
    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_step_ok;
    logic [POS_W-1:0]       w_at_len;
    logic [POS_W-1:0]       w_cl;
    logic [POS_W-1:0]       w_acc_cl;
    logic                   w_in_pat;
    logic                   w_quest;

    assign w_glob = (i_mode == MODE_GLOB) || (i_mode == MODE_GLOB_PREFIX);
    assign w_tail = (i_mode == MODE_GLOB_PREFIX) || (i_mode == MODE_PREFIX);

    always_comb begin
        w_in_pat = 1'b0;
        w_quest  = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_in_pat     = (LEN_W'(i) < i_len);
            w_quest      = w_glob && (i_chars[i] == QUEST_BYTE);
            w_star[i]    = w_in_pat && w_glob && (i_chars[i] == STAR_BYTE);
            w_step_ok[i] = w_in_pat && !w_star[i] && ((i_chars[i] == i_ch) || w_quest);
        end
        for (int i = 0; i < POS_W; i++) begin
            w_at_len[i] = (LEN_W'(i) == i_len);
        end
    end

    assign w_cl = f_star_closure(i_active, w_star);

    assign o_next = {w_cl[PATTERN_MAX-1:0] & w_step_ok, 1'b0}
                  | (w_cl & {1'b0, w_star})
                  | (w_cl & w_at_len & {POS_W{w_tail}});

    assign w_acc_cl = f_star_closure(o_next, w_star);
    assign o_accept = |(w_acc_cl & w_at_len);

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_entry_matcher_top.sv =====
// Wildcard entry matcher.
// Input channel (i_valid / o_stall) carries one beat per item: i_op selects
// append pattern byte, entry byte or clear pattern; i_ch is the byte; i_last
// marks the final byte of an entry. Output channel (o_valid / i_stall) carries
// one beat per finished entry: o_matched and o_pattern_overflow.
// Config channel (i_cfg_valid / o_cfg_ready) writes the 2-bit match mode:
// glob, glob with trailing star, exact, prefix. Write it only while idle.
// An item is evaluated while it sits in the input register and its result
// is loaded into the output register when the item advances, so a result
// beat passes through the input register and then the output register.
// One item per cycle while o_stall is low; the 33-bit active-position
// vector is updated each time an item advances.
// Reset: pattern empty, overflow clear, mode glob, both registers empty.
// A stalled result holds in the output register; the item behind it waits
// in the input register only if it would produce a result too, and o_stall
// rises then. Other items keep flowing.
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_entry_matcher_top_macros.svh"

module wildcard_entry_matcher_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_matched,
    output logic            o_pattern_overflow,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);
    import wem_pkg::*;

    logic             r_in_valid;
    t_op              r_in_op;
    logic [CH_W-1:0]  r_in_ch;
    logic             r_in_last;
    t_mode            r_mode;
    logic [POS_W-1:0] r_active;
    logic [POS_W-1:0] n_active;
    logic             r_out_valid;
    logic             r_out_matched;
    logic             r_out_overflow;

    t_chars           w_chars;
    t_pat_status      w_status;
    logic [POS_W-1:0] w_next;
    logic             w_accept;
    logic             w_gives_result;
    logic             w_advance;
    logic             w_in_take;
    logic             w_append;
    logic             w_clear;
    logic [POS_W-1:0] w_pos_mask;

    assign w_gives_result = r_in_valid && (r_in_op == OP_ENTRY) && r_in_last;
    assign w_advance      = r_in_valid && (!w_gives_result || !r_out_valid || !i_stall);
    assign o_stall        = r_in_valid && !w_advance;
    assign w_in_take      = i_valid && !o_stall;
    assign w_append       = w_advance && (r_in_op == OP_APPEND);
    assign w_clear        = w_advance && (r_in_op == OP_CLEAR);
    assign o_cfg_ready    = 1'b1;

    wem_pattern_store u_pattern_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_append (w_append),
        .i_clear  (w_clear),
        .i_ch     (r_in_ch),
        .o_chars  (w_chars),
        .o_status (w_status)
    );

    wem_nfa_step u_nfa_step (
        .i_active (r_active),
        .i_chars  (w_chars),
        .i_len    (w_status.len),
        .i_mode   (r_mode),
        .i_ch     (r_in_ch),
        .o_next   (w_next),
        .o_accept (w_accept)
    );

    always_comb begin
        n_active = r_active;
        if (w_advance) begin
            case (r_in_op)
                OP_APPEND: n_active = POS_W'(1);
                OP_CLEAR:  n_active = POS_W'(1);
                OP_ENTRY:  n_active = r_in_last ? POS_W'(1) : w_next;
                default:   n_active = r_active;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_GLOB;
            r_active    <= POS_W'(1);
        end else begin
            r_active <= n_active;
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_gives_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_mode'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= t_op'(i_op);
            r_in_ch   <= i_ch;
            r_in_last <= i_last;
        end
        if (w_advance && w_gives_result) begin
            r_out_matched  <= w_accept;
            r_out_overflow <= w_status.overflow;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_matched          = r_out_matched;
    assign o_pattern_overflow = r_out_overflow;

    always_comb begin
        for (int i = 0; i < POS_W; i++) begin
            w_pos_mask[i] = (LEN_W'(i) <= w_status.len);
        end
    end

    `WEM_ASSERT_HOLDS(a_active_in_range, i_clk, i_rst_n,
        (r_active & ~w_pos_mask) == '0, "active position beyond pattern length")
    `WEM_ASSERT_HOLDS(a_len_bound, i_clk, i_rst_n,
        w_status.len <= LEN_W'(PATTERN_MAX), "pattern length beyond capacity")
    `WEM_ASSERT_HOLDS(a_ovf_full, i_clk, i_rst_n,
        !w_status.overflow || (w_status.len == LEN_W'(PATTERN_MAX)),
        "overflow flagged with room left")
    `WEM_ASSERT_NEXT(a_result_issued, i_clk, i_rst_n, w_advance && w_gives_result,
        r_out_valid, "entry end without result beat")
    `WEM_ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n, w_advance && w_gives_result,
        r_active == POS_W'(1), "positions not restarted after entry end")

endmodule

`default_nettype wire
